// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/tlvd_pkg.sv =====
`default_nettype none

package tlvd_pkg;

	// result kinds, carried on tuser
	localparam logic [1:0] KIND_OPEN   = 2'd0;
	localparam logic [1:0] KIND_CONT   = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// stream status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_MANY = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	localparam int QDEPTH = 8;
	localparam int QAW    = 3;
	localparam int TDATA_W = 48;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  item_index;
		logic [7:0]  item_type;
		logic [7:0]  data_byte;
		logic [15:0] byte_offset;
		logic [4:0]  item_count;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic v0;
		logic v1;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/tlv8_fragment_decoder.sv =====
`default_nettype none
// Path: an accepted byte is held in the input register, then decoded into the result
//   queue; when the queue is empty its results then show at the queue head on m_t*.
// Throughput: one byte per cycle while s_tready is high; a stream-end byte yields up to two results, and
//   s_tready drops while more than four results wait in the eight-entry queue.
// Reset: arst_n clears the parser to the start of a stream and empties the queue.
module tlv8_fragment_decoder #(
	parameter int MAX_ITEMS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  wire logic        s_tlast,   // stream_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [3:0] item_index, [11:4] item_type,
	                                    // [19:12] data_byte, [35:20] byte_offset,
	                                    // [40:36] item_count, [42:41] status, zero above
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last
);
	import tlvd_pkg::*;

	logic         vld_s1;
	logic [7:0]   byte_s1;
	logic         end_s1;
	result_t      res0, res1, out_res;
	push_t        push;
	logic [QAW:0] q_count;

	// room for the byte in flight and the one taken now, two results each
	assign s_tready = (q_count <= (QAW+1)'(QDEPTH - 4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	tlvd_parse #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s1),
		.in_byte(byte_s1),
		.in_end (end_s1),
		.res0   (res0),
		.res1   (res1),
		.push   (push)
	);

	tlvd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res0   (res0),
		.res1   (res1),
		.out_vld(m_tvalid),
		.out_rdy(m_tready),
		.out_res(out_res),
		.count  (q_count)
	);

	assign m_tdata = {5'b0, out_res.status, out_res.item_count, out_res.byte_offset,
		out_res.data_byte, out_res.item_type, out_res.item_index};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== rtl/tlvd_parse.sv =====
`default_nettype none
`include "assert_macros.svh"

module tlvd_parse #(
	parameter int MAX_ITEMS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire logic [7:0]        in_byte,
	input  wire logic              in_end,
	output tlvd_pkg::result_t      res0,
	output tlvd_pkg::result_t      res1,
	output tlvd_pkg::push_t        push
);
	import tlvd_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	logic [1:0]    phase_q, phase_n;
	logic [7:0]    cur_type_q, cur_type_n;
	logic [7:0]    bytes_left_q, bytes_left_n;
	logic [7:0]    prev_type_q, prev_type_n;
	logic          prev_full_q, prev_full_n;
	logic [CW-1:0] items_q, items_n;
	logic [15:0]   offset_q, offset_n;
	logic [1:0]    err_q, err_n;

	logic          trunc;
	logic          cont;
	logic [7:0]    left_dec;
	logic [CW-1:0] idx_m1;
	logic [CW+3:0] idx_ext;
	logic [CW+4:0] cnt_ext;

	assign cont     = prev_full_q && (in_byte == prev_type_q) && (items_q != '0);
	assign left_dec = (bytes_left_q == 8'd0) ? 8'd0 : bytes_left_q - 8'd1;

	always_comb begin
		phase_n      = phase_q;
		cur_type_n   = cur_type_q;
		bytes_left_n = bytes_left_q;
		prev_type_n  = prev_type_q;
		prev_full_n  = prev_full_q;
		items_n      = items_q;
		offset_n     = offset_q;
		err_n        = err_q;
		trunc        = 1'b0;
		idx_m1       = '0;
		idx_ext      = '0;
		cnt_ext      = '0;
		res0         = '0;
		res1         = '0;
		push         = '0;

		if (in_vld) begin
			unique case (phase_q)
				PH_LEN: begin
					bytes_left_n = in_byte;
					prev_type_n  = cur_type_q;
					prev_full_n  = (in_byte == 8'hff);
					phase_n      = (in_byte == 8'd0) ? PH_TYPE : PH_DATA;
					trunc        = in_end && (in_byte != 8'd0);
				end
				PH_DATA: begin
					if (err_q == ST_OK) begin
						if (offset_q == 16'hffff) begin
							err_n = ST_TOO_LONG;
						end else begin
							push.v0          = 1'b1;
							res0.kind        = KIND_DATA;
							res0.item_type   = cur_type_q;
							res0.data_byte   = in_byte;
							res0.byte_offset = offset_q;
							offset_n         = offset_q + 16'd1;
						end
					end
					bytes_left_n = left_dec;
					if (left_dec == 8'd0) begin
						phase_n = PH_TYPE;
					end else begin
						trunc = in_end;
					end
				end
				default: begin
					// type byte; an unused phase code is handled the same way
					cur_type_n = in_byte;
					if (err_q == ST_OK) begin
						if (cont) begin
							push.v0        = 1'b1;
							res0.kind      = KIND_CONT;
							res0.item_type = in_byte;
						end else if (items_q >= MAX_CNT) begin
							err_n = ST_TOO_MANY;
						end else begin
							items_n        = items_q + CW'(1);
							offset_n       = 16'd0;
							push.v0        = 1'b1;
							res0.kind      = KIND_OPEN;
							res0.item_type = in_byte;
						end
					end
					phase_n = PH_LEN;
					trunc   = in_end;
				end
			endcase

			// index of the item a result belongs to, after this byte's update
			idx_m1  = items_n - CW'(1);
			idx_ext = {4'b0, idx_m1};
			cnt_ext = {5'b0, items_n};

			res0.item_index = idx_ext[3:0];
			res0.item_count = cnt_ext[4:0];

			if (in_end) begin
				if (trunc && (err_n == ST_OK)) begin
					err_n = ST_TRUNC;
				end
				push.v1         = 1'b1;
				res1.kind       = KIND_STATUS;
				res1.item_count = cnt_ext[4:0];
				res1.status     = err_n;
				res1.last       = 1'b1;
				// start a fresh stream on the next byte
				phase_n      = PH_TYPE;
				cur_type_n   = 8'd0;
				bytes_left_n = 8'd0;
				prev_type_n  = 8'hff;
				prev_full_n  = 1'b0;
				items_n      = '0;
				offset_n     = 16'd0;
				err_n        = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			cur_type_q   <= 8'd0;
			bytes_left_q <= 8'd0;
			prev_type_q  <= 8'hff;
			prev_full_q  <= 1'b0;
			items_q      <= '0;
			offset_q     <= 16'd0;
			err_q        <= ST_OK;
		end else begin
			phase_q      <= phase_n;
			cur_type_q   <= cur_type_n;
			bytes_left_q <= bytes_left_n;
			prev_type_q  <= prev_type_n;
			prev_full_q  <= prev_full_n;
			items_q      <= items_n;
			offset_q     <= offset_n;
			err_q        <= err_n;
		end
	end

	`ASSERT_CLK(a_err_sticky, clk, arst_n,
		(err_q != ST_OK && !(in_vld && in_end)) |=> (err_q == $past(err_q)),
		"error code changed before stream end")
	`ASSERT_CLK(a_end_clears, clk, arst_n,
		(in_vld && in_end) |=> (phase_q == PH_TYPE && items_q == '0 && err_q == ST_OK),
		"state not cleared after stream end")
	`ASSERT_NEVER(a_data_no_item, clk, arst_n,
		(phase_q == PH_DATA && err_q == ST_OK && items_q == '0),
		"data phase without an open item")

endmodule

`default_nettype wire

// ===== rtl/tlvd_queue.sv =====
`default_nettype none
`include "assert_macros.svh"

module tlvd_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tlvd_pkg::push_t         push,
	input  wire tlvd_pkg::result_t       res0,
	input  wire tlvd_pkg::result_t       res1,
	output logic                         out_vld,
	input  wire logic                    out_rdy,
	output tlvd_pkg::result_t            out_res,
	output logic [tlvd_pkg::QAW:0]       count
);
	import tlvd_pkg::*;

	result_t        mem [QDEPTH];
	logic [QAW-1:0] head_q, tail_q, tail2;
	logic [QAW:0]   count_q;
	logic [QAW:0]   push_cnt;
	logic           pop;

	assign tail2    = tail_q + QAW'(push.v0);
	assign push_cnt = (QAW+1)'(push.v0) + (QAW+1)'(push.v1);
	assign out_vld  = (count_q != '0);
	assign out_res  = mem[head_q];
	assign pop      = out_vld && out_rdy;
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[tail_q] <= res0;
		end
		if (push.v1) begin
			mem[tail2] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + QAW'(push_cnt);
			head_q  <= head_q + QAW'(pop);
			count_q <= count_q + push_cnt - (QAW+1)'(pop);
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n,
		(count_q + push_cnt > (QAW+1)'(QDEPTH) + (QAW+1)'(pop)),
		"result queue overflow")
	`ASSERT_CLK(a_empty_ptrs, clk, arst_n,
		(count_q == '0) |-> (head_q == tail_q),
		"queue empty with unequal pointers")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import tlvd_pkg::*;

	localparam int ITEM_LIMIT = 16;

	typedef enum logic [1:0] {
		PARSE_TYPE,
		PARSE_LEN,
		PARSE_DATA
	} parse_phase_e;

	// Predicts decoder results per accepted byte and matches them in order.
	class tlv8_result_tracker;
		result_t pending_results[$];
		parse_phase_e parse_at;
		logic [7:0] cur_type;
		logic [7:0] last_type;
		bit last_full;
		int data_left;
		int items_open;
		int next_offset;
		logic [1:0] fault;
		int errors;
		int kind_seen[4];
		int status_seen[4];

		function new();
			errors = 0;
			foreach (kind_seen[k]) kind_seen[k] = 0;
			foreach (status_seen[k]) status_seen[k] = 0;
			clear();
		endfunction

		function void clear();
			parse_at = PARSE_TYPE;
			cur_type = 8'h00;
			last_type = 8'hff;
			last_full = 1'b0;
			data_left = 0;
			items_open = 0;
			next_offset = 0;
			fault = ST_OK;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void add(logic [1:0] kind, int idx, logic [7:0] typ, logic [7:0] data,
				int offset, logic [1:0] st, logic fin);
			result_t r;
			r.kind = kind;
			r.item_index = idx[3:0];
			r.item_type = typ;
			r.data_byte = data;
			r.byte_offset = offset[15:0];
			r.item_count = items_open[4:0];
			r.status = st;
			r.last = fin;
			pending_results.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b, logic fin);
			bit trunc;
			bit cont;
			trunc = 1'b0;
			case (parse_at)
				PARSE_LEN: begin
					data_left = int'(b);
					last_type = cur_type;
					last_full = (b == 8'hff);
					parse_at = (b == 8'h00) ? PARSE_TYPE : PARSE_DATA;
					if (fin && b != 8'h00)
						trunc = 1'b1;
				end
				PARSE_DATA: begin
					if (fault == ST_OK) begin
						if (next_offset >= 'hffff) begin
							fault = ST_TOO_LONG;
						end else begin
							add(KIND_DATA, items_open - 1, cur_type, b, next_offset, ST_OK, 1'b0);
							next_offset++;
						end
					end
					if (data_left > 0)
						data_left--;
					if (data_left == 0)
						parse_at = PARSE_TYPE;
					else if (fin)
						trunc = 1'b1;
				end
				default: begin
					cont = last_full && b == last_type && items_open > 0;
					cur_type = b;
					if (fault == ST_OK) begin
						if (cont) begin
							add(KIND_CONT, items_open - 1, b, 8'h00, 0, ST_OK, 1'b0);
						end else if (items_open >= ITEM_LIMIT) begin
							fault = ST_TOO_MANY;
						end else begin
							items_open++;
							next_offset = 0;
							add(KIND_OPEN, items_open - 1, b, 8'h00, 0, ST_OK, 1'b0);
						end
					end
					parse_at = PARSE_LEN;
					if (fin)
						trunc = 1'b1;
				end
			endcase
			if (fin) begin
				if (trunc && fault == ST_OK)
					fault = ST_TRUNC;
				add(KIND_STATUS, 0, 8'h00, 8'h00, 0, fault, 1'b1);
				clear();
			end
		endfunction

		function int differs(string what, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void check_result(logic [TDATA_W-1:0] d, logic [1:0] u, logic l);
			result_t want;
			int bad;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tuser %0d tdata %h tlast %0d",
					$time, u, d, l);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			bad = 0;
			bad += differs("kind", want.kind, u);
			bad += differs("item_index", want.item_index, d[3:0]);
			bad += differs("item_type", want.item_type, d[11:4]);
			bad += differs("data_byte", want.data_byte, d[19:12]);
			bad += differs("byte_offset", want.byte_offset, d[35:20]);
			bad += differs("item_count", want.item_count, d[40:36]);
			bad += differs("status", want.status, d[42:41]);
			bad += differs("tdata padding", 16'h0000, d[47:43]);
			bad += differs("last", want.last, l);
			if (bad != 0)
				errors++;
			kind_seen[want.kind]++;
			if (want.kind == KIND_STATUS)
				status_seen[want.status]++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	tlv8_result_tracker tracker = new();
	logic [7:0] strm[$];
	int burst_left = 0;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;
	int bytes_sent = 0;
	int streams_sent = 0;

	tlv8_fragment_decoder #(
		.MAX_ITEMS(ITEM_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Receiver: stretches of always-ready, light and heavy stalls; one long hold-off on request.
	initial begin
		int mode;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 2);
				repeat ($urandom_range(10, 150)) begin
					if (mode == 0)
						m_tready <= 1'b1;
					else if (mode == 1)
						m_tready <= ($urandom_range(0, 3) != 0);
					else
						m_tready <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end
		end
	end

	task send_byte(input logic [7:0] b, input logic fin);
		if (!no_gaps && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_byte(b, fin);
		if (burst_left > 0)
			burst_left--;
		bytes_sent++;
	endtask

	task send_stream();
		for (int i = 0; i < strm.size(); i++)
			send_byte(strm[i], i == strm.size() - 1);
		streams_sent++;
	endtask

	function void add_element(logic [7:0] t, int len);
		strm.push_back(t);
		strm.push_back(len[7:0]);
		repeat (len) strm.push_back(8'($urandom_range(0, 255)));
	endfunction

	function void build_random_stream();
		int pick;
		int n_el;
		int len;
		int roll;
		int cut;
		int prev_len;
		logic [7:0] t;
		logic [7:0] prev_t;
		strm.delete();
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			// raw noise, no framing intended
			repeat ($urandom_range(1, 12)) strm.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_el = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 5);
		prev_t = 8'($urandom_range(0, 255));
		prev_len = 0;
		for (int k = 0; k < n_el; k++) begin
			// favor a repeated type after a full element so fragments show up
			if (prev_len == 255 ? $urandom_range(0, 2) != 0 : $urandom_range(0, 3) == 0)
				t = prev_t;
			else
				t = 8'($urandom_range(0, 255));
			roll = $urandom_range(0, 59);
			if (roll == 0)
				len = 255;
			else if (roll < 9)
				len = 0;
			else if (roll < 11)
				len = $urandom_range(9, 64);
			else
				len = $urandom_range(1, 8);
			add_element(t, len);
			prev_t = t;
			prev_len = len;
		end
		if (pick <= 2) begin
			cut = $urandom_range(0, strm.size() - 1);
			strm = strm[0:cut];
		end
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end on a type byte
		strm = '{8'h5a};
		send_stream();
		// empty element, end on a zero length
		strm = '{8'h00, 8'h00};
		send_stream();
		strm = '{8'hff, 8'h01, 8'hff};
		send_stream();
		// end inside data, then on a nonzero length
		strm = '{8'h81, 8'h04, 8'ha5};
		send_stream();
		strm = '{8'h3c, 8'h02};
		send_stream();
		// same type without a full previous length opens a new item
		strm = '{8'h11, 8'h01, 8'h55, 8'h11, 8'h00, 8'h22, 8'h00};
		send_stream();

		// fragment merge back to back, then a short repeat that opens a new item
		no_gaps = 1'b1;
		strm.delete();
		add_element(8'h07, 255);
		add_element(8'h07, 2);
		add_element(8'h07, 1);
		send_stream();
		strm.delete();
		add_element(8'h09, 255);
		add_element(8'h0a, 0);
		send_stream();
		no_gaps = 1'b0;
		// exactly the item limit
		strm.delete();
		for (int k = 0; k < ITEM_LIMIT; k++)
			add_element(8'(k * 3), 0);
		send_stream();
		// one item too many, then a truncated end that must not override it
		strm.delete();
		for (int k = 0; k <= ITEM_LIMIT; k++)
			add_element(8'(k + 100), (k == ITEM_LIMIT) ? 2 : 1);
		strm.push_back(8'h44);
		send_stream();

		hold_req = 1'b1;
		while (bytes_sent < 1150) begin
			build_random_stream();
			send_stream();
		end
		s_tvalid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d streams; results: %0d opened, %0d continued, %0d data, %0d status",
			bytes_sent, streams_sent, tracker.kind_seen[KIND_OPEN], tracker.kind_seen[KIND_CONT],
			tracker.kind_seen[KIND_DATA], tracker.kind_seen[KIND_STATUS]);
		$display("Stream endings: ok %0d, too many %0d, truncated %0d, too long %0d",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_TOO_MANY],
			tracker.status_seen[ST_TRUNC], tracker.status_seen[ST_TOO_LONG]);
		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("Timeout: %0d results still expected", tracker.pending());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
